>>> rtl/stxenc_pkg.sv
// ----------------------------------------------------------------------------
// stxenc_pkg
// Shared types, codes and the crc-8 helper for the stx/etx frame encoder.
// ----------------------------------------------------------------------------
package stxenc_pkg;

  // crc-8 polynomial and seed
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcSeed = 8'hFF;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_START_BYTE  = 2'd0,
    REG_END_BYTE    = 2'd1,
    REG_ESCAPE_BYTE = 2'd2,
    REG_MAX_LENGTH  = 2'd3
  } reg_index_e;

  // line byte kinds, in send order; bit positions of cmd_t.steps
  localparam int NumSteps = 7;
  typedef enum logic [2:0] {
    STEP_START = 3'd0,
    STEP_DESC  = 3'd1,
    STEP_DATA  = 3'd2,
    STEP_CESC  = 3'd3,
    STEP_CRC   = 3'd4,
    STEP_END   = 3'd5,
    STEP_ERR   = 3'd6
  } step_e;

  // configuration registers as seen by front and back
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic [8:0] max_output_length;
  } cfg_regs_t;

  // one classified item: which line bytes to send plus their payload
  typedef struct packed {
    logic [NumSteps-1:0] steps;
    logic [7:0]          data;
    logic [7:0]          crc;
  } cmd_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/stx_etx_frame_encoder_crc8.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_encoder_crc8
// STX/ETX frame encoder with byte stuffing and CRC-8 (poly 0x31, seed 0xFF).
// ----------------------------------------------------------------------------
// Each body byte is taken by the front end, which decides the whole group
// of line bytes it causes (start marker, escape, data, crc, end marker or
// the error result) and queues it; the back end sends those bytes one per
// cycle from an output register while out_ready does not stall it. An item
// thus produces one to six line bytes, two for an escaped body byte, and
// none for items dropped after an overflow. Sustained rate is set by the
// single output byte per cycle. Input is accepted whenever the two-entry
// command queue has room, independent of output stalls.
module stx_etx_frame_encoder_crc8
  import stxenc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       frame_done,
  output logic       status
);

  cfg_regs_t  cfg;
  logic [7:0] crc_start;
  logic       push;
  cmd_t       push_cmd;
  logic       full;
  logic       pop;
  logic       q_valid;
  cmd_t       q_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers; crc of the start marker kept alongside
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte        <= 8'h02;
      cfg.end_byte          <= 8'h03;
      cfg.escape_byte       <= 8'h10;
      cfg.max_output_length <= 9'd256;
      crc_start             <= crc8_update(CrcSeed, 8'h02);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_e'(cfg_index))
        REG_START_BYTE: begin
          cfg.start_byte <= cfg_data[7:0];
          crc_start      <= crc8_update(CrcSeed, cfg_data[7:0]);
        end
        REG_END_BYTE:    cfg.end_byte          <= cfg_data[7:0];
        REG_ESCAPE_BYTE: cfg.escape_byte       <= cfg_data[7:0];
        REG_MAX_LENGTH:  cfg.max_output_length <= cfg_data;
        default:         cfg.end_byte          <= cfg.end_byte;
      endcase
    end
  end

  stxenc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .crc_start  (crc_start),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push       (push),
    .cmd        (push_cmd),
    .queue_full (full)
  );

  stxenc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  stxenc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .frame_done  (frame_done),
    .status      (status)
  );

endmodule

>>> rtl/stxenc_front.sv
// ----------------------------------------------------------------------------
// stxenc_front
// Accepts body bytes, tracks frame state, length and crc, and turns each
// item into a command listing the line bytes the back end has to send.
// ----------------------------------------------------------------------------
module stxenc_front
  import stxenc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  logic [7:0] crc_start,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       push,
  output cmd_t       cmd,
  input  logic       queue_full
);

  localparam int LimW = 13;
  localparam logic [LimW-1:0] MaxFrame = LimW'(MAX_FRAME_BYTES);

  logic       in_frame;
  logic       dropping;
  logic [8:0] count;
  logic [7:0] crc;

  logic       accept;
  logic [9:0] lim;
  logic [7:0] crc_in;
  logic [7:0] crc_next;
  logic       esc_d;
  logic       esc_c;
  logic [9:0] p1;
  logic [9:0] p2;
  logic [9:0] p3;
  logic [9:0] p4;
  logic       ok_s;
  logic       ok_d;
  logic       ok_c;
  logic       ok_e;
  logic       ok_all;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && !dropping;

  // effective frame length limit
  always_comb begin
    if ({4'b0, cfg.max_output_length} > MaxFrame) begin
      lim = MaxFrame[9:0];
    end else begin
      lim = {1'b0, cfg.max_output_length};
    end
  end

  // crc over start marker (precomputed), the frame's earlier bytes and this byte
  assign crc_in   = in_frame ? crc : crc_start;
  assign crc_next = crc8_update(crc_in, data_byte);

  assign esc_d = (data_byte == cfg.start_byte) || (data_byte == cfg.end_byte) ||
                 (data_byte == cfg.escape_byte);
  assign esc_c = (crc_next == cfg.start_byte) || (crc_next == cfg.end_byte) ||
                 (crc_next == cfg.escape_byte);

  // running output position after each piece, and room checks
  assign p1 = {1'b0, count} + (in_frame ? 10'd0 : 10'd1);
  assign p2 = p1 + (esc_d ? 10'd2 : 10'd1);
  assign p3 = p2 + (esc_c ? 10'd2 : 10'd1);
  assign p4 = p3 + 10'd1;

  assign ok_s   = in_frame || (p1 <= lim);
  assign ok_d   = ok_s && (p2 <= lim);
  assign ok_c   = ok_d && (p3 <= lim);
  assign ok_e   = ok_c && (p4 <= lim);
  assign ok_all = last_byte ? ok_e : ok_d;

  // command build
  always_comb begin
    cmd = '0;
    cmd.data = data_byte;
    cmd.crc  = crc_next;
    cmd.steps[STEP_START] = !in_frame && ok_s;
    cmd.steps[STEP_DESC]  = ok_d && esc_d;
    cmd.steps[STEP_DATA]  = ok_d;
    cmd.steps[STEP_CESC]  = last_byte && ok_c && esc_c;
    cmd.steps[STEP_CRC]   = last_byte && ok_c;
    cmd.steps[STEP_END]   = last_byte && ok_e;
    cmd.steps[STEP_ERR]   = !ok_all;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      dropping <= 1'b0;
      count    <= '0;
      crc      <= CrcSeed;
    end else if (accept) begin
      if (dropping) begin
        if (last_byte) begin
          dropping <= 1'b0;
        end
      end else if (!ok_all || last_byte) begin
        in_frame <= 1'b0;
        count    <= '0;
        crc      <= CrcSeed;
        dropping <= !ok_all && !last_byte;
      end else begin
        in_frame <= 1'b1;
        count    <= p2[8:0];
        crc      <= crc_next;
      end
    end
  end

endmodule

>>> rtl/stxenc_queue.sv
// ----------------------------------------------------------------------------
// stxenc_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module stxenc_queue
  import stxenc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/stxenc_back.sv
// ----------------------------------------------------------------------------
// stxenc_back
// Walks each queued command and sends its line bytes one per cycle through
// an output register, as long as out_ready does not stall it.
// ----------------------------------------------------------------------------
module stxenc_back
  import stxenc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       frame_done,
  output logic       status
);

  logic [NumSteps-1:0] mask;
  logic [7:0]          cur_data;
  logic [7:0]          cur_crc;

  logic                adv;
  step_e               sel;
  logic [NumSteps-1:0] low;
  logic [NumSteps-1:0] rest;

  // pick the first pending line byte
  always_comb begin
    sel = STEP_START;
    for (int i = NumSteps - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = step_e'(3'(i));
      end
    end
  end

  assign low  = NumSteps'(1) << sel;
  assign rest = mask & ~low;
  assign adv  = (|mask) && (!out_valid || out_ready);
  assign pop  = q_valid && ((mask == '0) || (adv && (rest == '0)));

  // current command
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (pop) begin
      mask <= q_cmd.steps;
    end else if (adv) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_data <= q_cmd.data;
      cur_crc  <= q_cmd.crc;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= |mask;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      last_of_run <= (rest == '0);
      frame_done  <= 1'b0;
      status      <= 1'b0;
      case (sel)
        STEP_START: out_byte <= cfg.start_byte;
        STEP_DESC:  out_byte <= cfg.escape_byte;
        STEP_DATA:  out_byte <= cur_data;
        STEP_CESC:  out_byte <= cfg.escape_byte;
        STEP_CRC:   out_byte <= cur_crc;
        STEP_END: begin
          out_byte   <= cfg.end_byte;
          frame_done <= 1'b1;
        end
        STEP_ERR: begin
          out_byte   <= 8'd0;
          frame_done <= 1'b1;
          status     <= 1'b1;
        end
        default:    out_byte <= 8'd0;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (frame_done && (out_byte == 8'd0)))
    else $error("error result malformed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> last_of_run)
    else $error("frame end not last of run");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> (mask != '0))
    else $error("popped command with no line bytes");
`endif

endmodule
